[rtl/core/sha1_pkg.sv]
// sha1_pkg: shared types, constants and state encoding for the SHA-1 engine.
// No dependencies; compiled before every other file in rtl/core.

package sha1_pkg;

    localparam int WORDS_DIGEST = 5;
    localparam int WORDS_BLOCK  = 16;

    localparam logic [31:0] INIT_H [WORDS_DIGEST] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] ROUND_K [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;

    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [6:0] ROUND_P1   = 7'd20;
    localparam logic [6:0] ROUND_P2   = 7'd40;
    localparam logic [6:0] ROUND_P3   = 7'd60;
    localparam logic [2:0] WORD_LAST  = 3'd4;
    localparam logic [5:0] FILL_LAST  = 6'd63;

    typedef enum logic [1:0] {
        PH_CHOOSE  = 2'd0,
        PH_PARITY1 = 2'd1,
        PH_MAJOR   = 2'd2,
        PH_PARITY2 = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        SEL_DATA,
        SEL_MARK,
        SEL_ZERO,
        SEL_LEN
    } byte_sel_t;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       has_byte;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    typedef struct packed {
        logic       push_byte;
        byte_sel_t  byte_sel;
        logic       load_work;
        logic       round_en;
        phase_t     phase;
        logic       chain_add;
        logic       reinit;
        logic [2:0] word_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic fill_last;
        logic fill_ge56;
    } dp_status_t;

endpackage

[rtl/core/sha1_datapath.sv]
// sha1_datapath: byte packing, 16-word schedule window, round unit, chaining value.
// Depends on sha1_pkg; driven by sha1_ctrl through dp_cmd_t.

module sha1_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sha1_pkg::dp_cmd_t     cmd,
    input  logic [7:0]            data_byte,
    output sha1_pkg::dp_status_t  status,
    output logic [31:0]           digest_word
);
    import sha1_pkg::*;

    logic [31:0] chain_reg [WORDS_DIGEST];
    logic [31:0] chain_next [WORDS_DIGEST];
    logic [31:0] w_reg [WORDS_BLOCK];
    logic [23:0] part_reg;
    logic [5:0]  fill_reg;
    logic [63:0] msg_bytes_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;

    logic [7:0]  push_val;
    logic [63:0] bit_len;
    logic [7:0]  len_byte;
    logic [31:0] f_val;
    logic [31:0] t_val;
    logic [31:0] w_new;

    assign bit_len  = {msg_bytes_reg[60:0], 3'b000};
    assign len_byte = bit_len[{~fill_reg[2:0], 3'b000} +: 8];

    always_comb begin
        unique case (cmd.byte_sel)
            SEL_DATA: push_val = data_byte;
            SEL_MARK: push_val = PAD_MARK_BYTE;
            SEL_ZERO: push_val = 8'h00;
            SEL_LEN:  push_val = len_byte;
            default:  push_val = 8'h00;
        endcase
    end

    always_comb begin
        unique case (cmd.phase)
            PH_CHOOSE:  f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            PH_MAJOR:   f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            PH_PARITY1,
            PH_PARITY2: f_val = b_reg ^ c_reg ^ d_reg;
            default:    f_val = b_reg ^ c_reg ^ d_reg;
        endcase
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + ROUND_K[cmd.phase] + w_reg[0];

    // next schedule word from the fixed taps of the window
    always_comb begin
        logic [31:0] x;
        x = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        w_new = {x[30:0], x[31]};
    end

    always_comb begin
        for (int i = 0; i < WORDS_DIGEST; i++) begin
            chain_next[i] = chain_reg[i];
        end
        if (cmd.chain_add) begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
            chain_next[4] = chain_reg[4] + e_reg;
        end else if (cmd.reinit) begin
            for (int i = 0; i < WORDS_DIGEST; i++) begin
                chain_next[i] = INIT_H[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WORDS_DIGEST; i++) begin
                chain_reg[i] <= INIT_H[i];
            end
            fill_reg      <= '0;
            msg_bytes_reg <= '0;
        end else begin
            for (int i = 0; i < WORDS_DIGEST; i++) begin
                chain_reg[i] <= chain_next[i];
            end
            if (cmd.reinit) begin
                fill_reg      <= '0;
                msg_bytes_reg <= '0;
            end else if (cmd.push_byte) begin
                fill_reg <= fill_reg + 6'd1;
                if (cmd.byte_sel == SEL_DATA) begin
                    msg_bytes_reg <= msg_bytes_reg + 64'd1;
                end
            end
        end
    end

    // schedule window and working variables carry no reset
    always_ff @(posedge aclk) begin
        if (cmd.push_byte) begin
            if (fill_reg[1:0] == 2'b11) begin
                for (int i = 0; i < WORDS_BLOCK - 1; i++) begin
                    w_reg[i] <= w_reg[i + 1];
                end
                w_reg[WORDS_BLOCK - 1] <= {part_reg, push_val};
            end else begin
                part_reg <= {part_reg[15:0], push_val};
            end
        end else if (cmd.round_en) begin
            for (int i = 0; i < WORDS_BLOCK - 1; i++) begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[WORDS_BLOCK - 1] <= w_new;
        end

        if (cmd.load_work) begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end else if (cmd.round_en) begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    assign status.fill_last = (fill_reg == FILL_LAST);
    assign status.fill_ge56 = &fill_reg[5:3];
    assign digest_word      = chain_reg[cmd.word_sel];

endmodule

[rtl/core/sha1_ctrl.sv]
// sha1_ctrl: sequencer for byte intake, padding, 80 rounds and digest readout.
// Depends on sha1_pkg; commands sha1_datapath through dp_cmd_t.

module sha1_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  has_byte,
    input  logic                  end_of_message,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            word_index,
    output logic                  last_word,
    input  sha1_pkg::dp_status_t  status,
    output sha1_pkg::dp_cmd_t     cmd
);
    import sha1_pkg::*;

    state_t     state_reg, state_next;
    logic [6:0] round_reg, round_next;
    logic [2:0] word_reg, word_next;
    logic       finishing_reg, finishing_next;
    logic       pad_first_reg, pad_first_next;
    logic       need_extra_reg, need_extra_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            round_reg      <= '0;
            word_reg       <= '0;
            finishing_reg  <= 1'b0;
            pad_first_reg  <= 1'b0;
            need_extra_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            round_reg      <= round_next;
            word_reg       <= word_next;
            finishing_reg  <= finishing_next;
            pad_first_reg  <= pad_first_next;
            need_extra_reg <= need_extra_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        round_next      = round_reg;
        word_next       = word_reg;
        finishing_next  = finishing_reg;
        pad_first_next  = pad_first_reg;
        need_extra_next = need_extra_reg;

        s_ready = 1'b0;
        m_valid = 1'b0;

        cmd           = '0;
        cmd.byte_sel  = SEL_DATA;
        cmd.word_sel  = word_reg;
        if (round_reg < ROUND_P1) begin
            cmd.phase = PH_CHOOSE;
        end else if (round_reg < ROUND_P2) begin
            cmd.phase = PH_PARITY1;
        end else if (round_reg < ROUND_P3) begin
            cmd.phase = PH_MAJOR;
        end else begin
            cmd.phase = PH_PARITY2;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    finishing_next = end_of_message;
                    pad_first_next = end_of_message;
                    if (has_byte) begin
                        cmd.push_byte = 1'b1;
                        cmd.byte_sel  = SEL_DATA;
                    end
                    // a byte closing the block compresses before any padding
                    if (has_byte && status.fill_last) begin
                        cmd.load_work = 1'b1;
                        round_next    = '0;
                        state_next    = ST_ROUND;
                    end else if (end_of_message) begin
                        state_next = ST_PAD;
                    end
                end
            end

            ST_PAD: begin
                cmd.push_byte = 1'b1;
                if (pad_first_reg) begin
                    cmd.byte_sel   = SEL_MARK;
                    pad_first_next = 1'b0;
                    // no room left for the length field in this block
                    if (status.fill_ge56) begin
                        need_extra_next = 1'b1;
                    end
                end else if (status.fill_ge56 && !need_extra_reg) begin
                    cmd.byte_sel = SEL_LEN;
                end else begin
                    cmd.byte_sel = SEL_ZERO;
                end
                if (status.fill_last) begin
                    cmd.load_work = 1'b1;
                    round_next    = '0;
                    state_next    = ST_ROUND;
                end
            end

            ST_ROUND: begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 7'd1;
                if (round_reg == ROUND_LAST) begin
                    state_next = ST_ADD;
                end
            end

            ST_ADD: begin
                cmd.chain_add = 1'b1;
                if (!finishing_reg) begin
                    state_next = ST_IDLE;
                end else if (pad_first_reg || need_extra_reg) begin
                    need_extra_next = 1'b0;
                    state_next      = ST_PAD;
                end else begin
                    word_next  = '0;
                    state_next = ST_OUT;
                end
            end

            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    word_next = word_reg + 3'd1;
                    if (word_reg == WORD_LAST) begin
                        cmd.reinit     = 1'b1;
                        finishing_next = 1'b0;
                        word_next      = '0;
                        state_next     = ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign word_index = word_reg;
    assign last_word  = (word_reg == WORD_LAST);

endmodule

[rtl/core/sha1_hash_engine_top.sv]
// sha1_hash_engine_top: streaming SHA-1 engine, controller plus datapath.
// Depends on sha1_pkg, sha1_ctrl and sha1_datapath.
//
// Input channel (s_): one transaction per item carrying an optional message byte
// and an end-of-message mark. Bytes are taken one per cycle while the block is idle.
// The 64th byte of a block starts compression: one round per cycle in the shared
// round unit, then the chaining update, and s_ready stays low from that
// transaction until the chaining update is done.
// At end of message the pad mark, zero fill and 64-bit length are pushed one byte
// per cycle up to the block boundary, then the block is compressed; an extra
// padding block is run when the mark lands in the last eight bytes.
// Result channel (m_): five transactions per message, digest word 0 (most
// significant) first, last_word set on word 4. m_valid holds while the receiver
// stalls and the engine accepts nothing until word 4 is taken; the chaining value,
// byte count and fill then return to their initial state for the next message.
// Reset (aresetn low, synchronous) returns the engine to idle with the initial
// hash words loaded; no partial message survives it.

module sha1_hash_engine_top (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sha1_pkg::in_item_t   s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sha1_pkg::out_item_t  m_item
);
    import sha1_pkg::*;

    dp_cmd_t     cmd;
    dp_status_t  status;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    sha1_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .has_byte       (s_item.has_byte),
        .end_of_message (s_item.end_of_message),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .word_index     (word_index),
        .last_word      (last_word),
        .status         (status),
        .cmd            (cmd)
    );

    sha1_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .data_byte   (s_item.msg_byte),
        .status      (status),
        .digest_word (digest_word)
    );

    assign m_item.digest_word = digest_word;
    assign m_item.word_index  = word_index;
    assign m_item.last_word   = last_word;

endmodule
